// File: hw/rtl/amus_pkg.sv
`timescale 1ns / 1ps
// amus_pkg.sv: widths, codes, constants and transaction types shared by the
// axis motion unit scaler modules. No dependencies.
package amus_pkg;

    localparam int MAX_AXES     = 8;
    localparam int NUM_AXES_DEF = 8;

    localparam int FUNC_W     = 3;
    localparam int AXIS_W     = 4;
    localparam int CFG_IDX_W  = $clog2(MAX_AXES);
    localparam int VAL_W      = 48;
    localparam int SCALE_W    = 32;
    localparam int SCALE_FRAC = 16;
    localparam int FRAC_BITS  = 16;

    // 48 x 32 multiply split into a 32-bit and a 16-bit slice of the value
    localparam int A_LO_W  = 32;
    localparam int A_HI_W  = VAL_W - A_LO_W;
    localparam int PROD_W  = VAL_W + SCALE_W;
    localparam int DIV_W   = PROD_W + SCALE_FRAC;
    localparam int QUO_W   = VAL_W;
    localparam int HI_W    = DIV_W - QUO_W;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;

    // scale query: Q16.16 register to FRAC_BITS fraction bits
    localparam int QRY_UP = (FRAC_BITS >= SCALE_FRAC) ? FRAC_BITS - SCALE_FRAC : 0;
    localparam int QRY_DN = (FRAC_BITS >= SCALE_FRAC) ? 0 : SCALE_FRAC - FRAC_BITS;

    localparam logic [SCALE_W-1:0] SCALE_DEF = SCALE_W'(1000 << SCALE_FRAC);
    localparam logic [SCALE_W-1:0] K_ONE     = SCALE_W'(1);
    localparam logic [SCALE_W-1:0] K_MS      = SCALE_W'(1000);
    localparam logic [SCALE_W-1:0] K_MS2     = SCALE_W'(1000000);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_POS_TO_PUL = 3'd0,
        FUNC_PUL_TO_POS = 3'd1,
        FUNC_VEL_TO_PUL = 3'd2,
        FUNC_PUL_TO_VEL = 3'd3,
        FUNC_ACC_TO_PUL = 3'd4,
        FUNC_PUL_TO_ACC = 3'd5,
        FUNC_SCALE_QRY  = 3'd6
    } t_func;

    // how the product becomes the dividend
    typedef enum logic [1:0] {
        MODE_PASS  = 2'd0,
        MODE_FLOOR = 2'd1,
        MODE_SHL   = 2'd2,
        MODE_SHR   = 2'd3
    } t_mode;

    typedef struct packed {
        logic [VAL_W-1:0]   a;
        logic [SCALE_W-1:0] b;
        logic [SCALE_W-1:0] dv;
        t_mode              mode;
        logic               neg;
        logic               bad;
    } t_mul_op;

    typedef struct packed {
        logic [A_LO_W+SCALE_W-1:0] pp_lo;
        logic [A_HI_W+SCALE_W-1:0] pp_hi;
        logic [SCALE_W-1:0]        dv;
        t_mode                     mode;
        logic                      neg;
        logic                      bad;
    } t_prod;

    typedef struct packed {
        logic [DIV_W-1:0]   dividend;
        logic [SCALE_W-1:0] dv;
        logic               neg;
        logic               bad;
    } t_q_entry;

    typedef struct packed {
        logic               empty;
        logic [Q_CNT_W-1:0] level;
    } t_q_status;

    typedef struct packed {
        logic [SCALE_W-1:0] rem;
        logic [QUO_W-1:0]   rq;
        logic [SCALE_W-1:0] dv;
        logic               neg;
        logic               bad;
        logic               ovf;
    } t_div_stage;

endpackage

// File: hw/rtl/amus_front.sv
`timescale 1ns / 1ps
// amus_front.sv: scale registers, input decode and two-stage 48x32 multiplier;
// hands dividend/divisor pairs to the queue. Depends on amus_pkg.
module amus_front #(
    parameter int NUM_AXES = amus_pkg::NUM_AXES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [amus_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [amus_pkg::SCALE_W-1:0]     i_cfg_data,
    input  logic                             i_push,
    output logic                             o_full,
    input  logic [amus_pkg::FUNC_W-1:0]      i_func,
    input  logic [amus_pkg::AXIS_W-1:0]      i_axis,
    input  logic signed [amus_pkg::VAL_W-1:0] i_value,
    input  amus_pkg::t_q_status              i_q_status,
    output logic                             o_q_wr,
    output amus_pkg::t_q_entry               o_q_wdata
);
    import amus_pkg::*;

    localparam int AX_IDX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

    logic [SCALE_W-1:0]  r_scale [NUM_AXES];
    logic                cfg_hit;
    logic [AX_IDX_W-1:0] cfg_sel;

    logic                r_s1_vld, r_s2_vld;
    t_mul_op             r_s1, n_s1;
    t_prod               r_s2, n_s2;

    logic                push_ok;
    logic [Q_CNT_W:0]    in_flight;
    logic                bad, neg, conv;
    logic [AX_IDX_W-1:0] ax_idx;
    logic [SCALE_W-1:0]  s_raw, s_eff, s_qry;
    logic [VAL_W-1:0]    val_u, m_abs, qry_val;
    logic [PROD_W-1:0]   prod;
    logic [DIV_W-1:0]    p_ext, dividend;

    assign cfg_hit = i_cfg_we && (int'(i_cfg_idx) < NUM_AXES);
    assign cfg_sel = i_cfg_idx[AX_IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_AXES; k++) r_scale[k] <= SCALE_DEF;
        end else if (cfg_hit) begin
            r_scale[cfg_sel] <= i_cfg_data;
        end
    end

    // credit check: everything in the two stages must find room in the queue
    assign in_flight = (Q_CNT_W+1)'(r_s1_vld) + (Q_CNT_W+1)'(r_s2_vld)
                     + (Q_CNT_W+1)'(i_q_status.level);
    assign o_full    = in_flight >= (Q_CNT_W+1)'(Q_DEPTH);
    assign push_ok   = i_push && !o_full;

    always_comb begin
        bad     = i_axis >= AXIS_W'(NUM_AXES);
        ax_idx  = bad ? '0 : i_axis[AX_IDX_W-1:0];
        s_raw   = r_scale[ax_idx];
        s_eff   = (s_raw == '0) ? SCALE_DEF : s_raw;
        s_qry   = bad ? SCALE_DEF : s_eff;
        qry_val = (VAL_W'(s_qry) << QRY_UP) >> QRY_DN;
        neg     = i_value[VAL_W-1];
        val_u   = i_value;
        m_abs   = neg ? (~val_u + VAL_W'(1)) : val_u;
        conv    = 1'b0;

        // default is a zero result through a divide by one
        n_s1.a    = '0;
        n_s1.b    = K_ONE;
        n_s1.dv   = K_ONE;
        n_s1.mode = MODE_PASS;
        n_s1.neg  = 1'b0;
        n_s1.bad  = 1'b0;

        case (i_func)
            FUNC_POS_TO_PUL: begin
                conv = 1'b1;
                n_s1.a = m_abs; n_s1.b = s_eff; n_s1.mode = MODE_FLOOR;
            end
            FUNC_PUL_TO_POS: begin
                conv = 1'b1;
                n_s1.a = {m_abs[VAL_W-1:FRAC_BITS], FRAC_BITS'(0)};
                n_s1.mode = MODE_SHL; n_s1.dv = s_eff;
            end
            FUNC_VEL_TO_PUL: begin
                conv = 1'b1;
                n_s1.a = m_abs; n_s1.b = s_eff; n_s1.mode = MODE_SHR; n_s1.dv = K_MS;
            end
            FUNC_PUL_TO_VEL: begin
                conv = 1'b1;
                n_s1.a = m_abs; n_s1.b = K_MS; n_s1.mode = MODE_SHL; n_s1.dv = s_eff;
            end
            FUNC_ACC_TO_PUL: begin
                conv = 1'b1;
                n_s1.a = m_abs; n_s1.b = s_eff; n_s1.mode = MODE_SHR; n_s1.dv = K_MS2;
            end
            FUNC_PUL_TO_ACC: begin
                conv = 1'b1;
                n_s1.a = m_abs; n_s1.b = K_MS2; n_s1.mode = MODE_SHL; n_s1.dv = s_eff;
            end
            FUNC_SCALE_QRY: begin
                n_s1.a = qry_val; n_s1.bad = bad;
            end
            default: ;
        endcase

        if (conv) n_s1.neg = neg;
        if (conv && bad) begin
            n_s1.a    = '0;
            n_s1.b    = K_ONE;
            n_s1.dv   = K_ONE;
            n_s1.mode = MODE_PASS;
            n_s1.neg  = 1'b0;
            n_s1.bad  = 1'b1;
        end
    end

    always_comb begin
        n_s2.pp_lo = (A_LO_W+SCALE_W)'(r_s1.a[A_LO_W-1:0]) * (A_LO_W+SCALE_W)'(r_s1.b);
        n_s2.pp_hi = (A_HI_W+SCALE_W)'(r_s1.a[VAL_W-1:A_LO_W]) * (A_HI_W+SCALE_W)'(r_s1.b);
        n_s2.dv    = r_s1.dv;
        n_s2.mode  = r_s1.mode;
        n_s2.neg   = r_s1.neg;
        n_s2.bad   = r_s1.bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= push_ok;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
        r_s2 <= n_s2;
    end

    always_comb begin
        prod  = PROD_W'(r_s2.pp_lo) + (PROD_W'(r_s2.pp_hi) << A_LO_W);
        p_ext = DIV_W'(prod);
        case (r_s2.mode)
            MODE_FLOOR: dividend = (p_ext >> (FRAC_BITS + SCALE_FRAC)) << FRAC_BITS;
            MODE_SHL:   dividend = p_ext << SCALE_FRAC;
            MODE_SHR:   dividend = p_ext >> SCALE_FRAC;
            default:    dividend = p_ext;
        endcase
    end

    assign o_q_wr             = r_s2_vld;
    assign o_q_wdata.dividend = dividend;
    assign o_q_wdata.dv       = r_s2.dv;
    assign o_q_wdata.neg      = r_s2.neg;
    assign o_q_wdata.bad      = r_s2.bad;

endmodule

// File: hw/rtl/amus_queue.sv
`timescale 1ns / 1ps
// amus_queue.sv: short FIFO between the multiplier front and the divider back.
// Depends on amus_pkg.
module amus_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  amus_pkg::t_q_entry   i_wdata,
    input  logic                 i_rd,
    output amus_pkg::t_q_entry   o_rdata,
    output amus_pkg::t_q_status  o_status
);
    import amus_pkg::*;

    t_q_entry           r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0] r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_wr) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_rd) r_rd_ptr <= r_rd_ptr + 1'b1;
            r_level <= r_level + Q_CNT_W'(i_wr) - Q_CNT_W'(i_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wr_ptr] <= i_wdata;
    end

    assign o_rdata        = r_mem[r_rd_ptr];
    assign o_status.level = r_level;
    assign o_status.empty = (r_level == '0);

endmodule

// File: hw/rtl/amus_back.sv
`timescale 1ns / 1ps
// amus_back.sv: pipelined restoring divider (one quotient bit per stage),
// saturation and the result register. Depends on amus_pkg.
module amus_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  amus_pkg::t_q_entry                i_q_rdata,
    input  amus_pkg::t_q_status               i_q_status,
    output logic                              o_q_rd,
    input  logic                              i_pop,
    output logic                              o_empty,
    output logic signed [amus_pkg::VAL_W-1:0] o_result,
    output logic                              o_bad_axis,
    output logic                              o_saturated
);
    import amus_pkg::*;

    function automatic t_div_stage div_step(input t_div_stage s);
        t_div_stage       o;
        logic [SCALE_W:0] t;
        logic             ge;
        t      = {s.rem, s.rq[QUO_W-1]};
        ge     = t >= {1'b0, s.dv};
        o      = s;
        o.rem  = ge ? SCALE_W'(t - {1'b0, s.dv}) : t[SCALE_W-1:0];
        o.rq   = {s.rq[QUO_W-2:0], ge};
        return o;
    endfunction

    logic             adv;
    logic [QUO_W:0]   r_vld;
    t_div_stage       r_st [QUO_W+1];
    t_div_stage       n_st [QUO_W+1];
    logic [HI_W-1:0]  d_hi;

    t_div_stage       fin;
    logic [QUO_W-1:0] lim, mag, n_result;
    logic             n_sat;
    logic             r_out_vld;
    logic [QUO_W-1:0] r_result;
    logic             r_bad, r_sat;

    // whole back end moves together; the result register frees on pop
    assign adv    = !r_out_vld || i_pop;
    assign o_q_rd = adv && !i_q_status.empty;

    always_comb begin
        // quotient of 2^48 or more is known up front from the high half
        d_hi          = i_q_rdata.dividend[DIV_W-1:QUO_W];
        n_st[0].ovf   = d_hi >= HI_W'(i_q_rdata.dv);
        n_st[0].rem   = n_st[0].ovf ? '0 : d_hi[SCALE_W-1:0];
        n_st[0].rq    = i_q_rdata.dividend[QUO_W-1:0];
        n_st[0].dv    = i_q_rdata.dv;
        n_st[0].neg   = i_q_rdata.neg;
        n_st[0].bad   = i_q_rdata.bad;
        for (int k = 1; k <= QUO_W; k++) n_st[k] = div_step(r_st[k-1]);
    end

    always_comb begin
        fin      = r_st[QUO_W];
        lim      = {fin.neg, {(QUO_W-1){~fin.neg}}};
        n_sat    = fin.ovf || (fin.rq > lim);
        mag      = n_sat ? lim : fin.rq;
        n_result = fin.neg ? (~mag + QUO_W'(1)) : mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_vld     <= {r_vld[QUO_W-1:0], !i_q_status.empty};
            r_out_vld <= r_vld[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k <= QUO_W; k++) r_st[k] <= n_st[k];
            r_result <= n_result;
            r_bad    <= fin.bad;
            r_sat    <= n_sat;
        end
    end

    assign o_empty     = !r_out_vld;
    assign o_result    = r_result;
    assign o_bad_axis  = r_bad;
    assign o_saturated = r_sat;

endmodule

// File: hw/rtl/axis_motion_unit_scaler.sv
`timescale 1ns / 1ps
// axis_motion_unit_scaler.sv: top level, mm <-> pulse conversion per axis.
// Depends on amus_pkg, amus_front, amus_queue, amus_back.
//
//  channel  | ports                                   | transaction when
//  ---------+-----------------------------------------+-------------------------
//  config   | i_cfg_we, i_cfg_idx, i_cfg_data         | i_cfg_we high
//  request  | push, full, i_func, i_axis, i_value     | push high, full low
//  result   | empty, pop, o_result, o_bad_axis,       | pop high, empty low
//           | o_saturated                             |
//
// Sustained rate one transaction per cycle while pop stays high. A request
// passes two multiplier stages, the 4-entry queue and the 48-stage divider
// pipeline (one quotient bit per stage) before its result shows.
// Synchronous reset clears all valid state and sets every scale to 1000.0.
// pop low holds the divider while a result waits; the front takes requests until
// its two stages plus the queue hold 4 transactions, then raises full.
module axis_motion_unit_scaler #(
    parameter int NUM_AXES = amus_pkg::NUM_AXES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [amus_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [amus_pkg::SCALE_W-1:0]      i_cfg_data,
    input  logic                              push,
    output logic                              full,
    input  logic [amus_pkg::FUNC_W-1:0]       i_func,
    input  logic [amus_pkg::AXIS_W-1:0]       i_axis,
    input  logic signed [amus_pkg::VAL_W-1:0] i_value,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [amus_pkg::VAL_W-1:0] o_result,
    output logic                              o_bad_axis,
    output logic                              o_saturated
);
    import amus_pkg::*;

    t_q_entry  q_wdata, q_rdata;
    t_q_status q_status;
    logic      q_wr, q_rd;

    amus_front #(
        .NUM_AXES (NUM_AXES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .o_full     (full),
        .i_func     (i_func),
        .i_axis     (i_axis),
        .i_value    (i_value),
        .i_q_status (q_status),
        .o_q_wr     (q_wr),
        .o_q_wdata  (q_wdata)
    );

    amus_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (q_wr),
        .i_wdata  (q_wdata),
        .i_rd     (q_rd),
        .o_rdata  (q_rdata),
        .o_status (q_status)
    );

    amus_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_rdata   (q_rdata),
        .i_q_status  (q_status),
        .o_q_rd      (q_rd),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result),
        .o_bad_axis  (o_bad_axis),
        .o_saturated (o_saturated)
    );

endmodule

// File: bench/amus_scaler_checker.sv
`timescale 1ns / 1ps
// amus_scaler_checker.sv: watches the request, result and config channels of
// axis_motion_unit_scaler, predicts each conversion and compares. Uses amus_pkg.
module amus_scaler_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [amus_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [amus_pkg::SCALE_W-1:0]   i_cfg_data,
    input  logic                           i_push,
    input  logic                           i_full,
    input  logic [amus_pkg::FUNC_W-1:0]    i_func,
    input  logic [amus_pkg::AXIS_W-1:0]    i_axis,
    input  logic [amus_pkg::VAL_W-1:0]     i_value,
    input  logic                           i_empty,
    input  logic                           i_pop,
    input  logic [amus_pkg::VAL_W-1:0]     i_result,
    input  logic                           i_bad_axis,
    input  logic                           i_saturated,
    output int                             o_errors,
    output int                             o_pending
);
    import amus_pkg::*;

    localparam int WIDE_W = 128;
    localparam logic [WIDE_W-1:0] POS_LIM = (WIDE_W'(1) << (VAL_W - 1)) - 1;
    localparam logic [WIDE_W-1:0] NEG_LIM = WIDE_W'(1) << (VAL_W - 1);
    localparam logic [WIDE_W-1:0] VEL_DIV = WIDE_W'(K_MS) << SCALE_FRAC;
    localparam logic [WIDE_W-1:0] ACC_DIV = WIDE_W'(K_MS2) << SCALE_FRAC;

    typedef struct packed {
        logic [VAL_W-1:0] result;
        logic             bad_axis;
        logic             saturated;
    } t_conv;

    logic [SCALE_W-1:0] scale_copy [MAX_AXES];
    t_conv              conv_q [$];
    int                 err_cnt = 0;

    assign o_errors = err_cnt;

    initial o_pending = 0;

    function automatic t_conv scale_convert(input logic [FUNC_W-1:0] fn,
                                            input logic [AXIS_W-1:0] ax,
                                            input logic [VAL_W-1:0]  raw);
        logic [VAL_W-1:0]  mag48;
        logic [WIDE_W-1:0] m, s, r, lim;
        logic              neg, bad;
        t_conv             o;
        neg   = raw[VAL_W-1];
        mag48 = neg ? -raw : raw;
        m     = WIDE_W'(mag48);
        bad   = (ax >= AXIS_W'(NUM_AXES_DEF));
        s     = WIDE_W'(scale_copy[ax[CFG_IDX_W-1:0]]);
        // zero register stands for 1000.0; an invalid axis queries as 1000.0
        if (bad || s == '0) s = WIDE_W'(SCALE_DEF);
        case (fn)
            FUNC_POS_TO_PUL: r = ((m * s) >> (FRAC_BITS + SCALE_FRAC)) << FRAC_BITS;
            FUNC_PUL_TO_POS: r = (((m >> FRAC_BITS) << FRAC_BITS) << SCALE_FRAC) / s;
            FUNC_VEL_TO_PUL: r = (m * s) / VEL_DIV;
            FUNC_PUL_TO_VEL: r = ((m * WIDE_W'(K_MS)) << SCALE_FRAC) / s;
            FUNC_ACC_TO_PUL: r = (m * s) / ACC_DIV;
            FUNC_PUL_TO_ACC: r = ((m * WIDE_W'(K_MS2)) << SCALE_FRAC) / s;
            FUNC_SCALE_QRY:  r = (s << QRY_UP) >> QRY_DN;
            default:         r = '0;
        endcase
        if (fn == FUNC_SCALE_QRY) begin
            neg = 1'b0;
        end else if (fn > FUNC_SCALE_QRY) begin
            // unused code: zero, no flags even on a bad axis
            neg = 1'b0;
            bad = 1'b0;
        end else if (bad) begin
            neg = 1'b0;
            r   = '0;
        end
        lim         = neg ? NEG_LIM : POS_LIM;
        o.saturated = (r > lim);
        if (o.saturated) r = lim;
        o.result   = neg ? -r[VAL_W-1:0] : r[VAL_W-1:0];
        o.bad_axis = bad;
        return o;
    endfunction

    task automatic check_field(input string what, input logic [VAL_W-1:0] want,
                               input logic [VAL_W-1:0] got);
        if (want !== got) begin
            err_cnt++;
            $display("%0t: %s mismatch: expected %h actual %h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_conv want;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_AXES; i++) scale_copy[i] = SCALE_DEF;
            conv_q.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (conv_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result: expected none actual %h",
                             $time, i_result);
                end else begin
                    want = conv_q.pop_front();
                    check_field("result", want.result, i_result);
                    check_field("bad_axis", VAL_W'(want.bad_axis), VAL_W'(i_bad_axis));
                    check_field("saturated", VAL_W'(want.saturated), VAL_W'(i_saturated));
                end
            end
            if (i_push && !i_full) conv_q.push_back(scale_convert(i_func, i_axis, i_value));
            if (i_cfg_we) scale_copy[i_cfg_idx] = i_cfg_data;
        end
        o_pending <= conv_q.size();
    end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// testbench.sv: stimulus and verdict for axis_motion_unit_scaler.
// Depends on amus_pkg, axis_motion_unit_scaler and amus_scaler_checker.
module testbench;
    import amus_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_NONE = 3'd7;
    localparam logic [VAL_W-1:0]  VAL_MAX   = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0]  VAL_MIN   = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [VAL_W-1:0]  ONE_Q     = VAL_W'(1) << FRAC_BITS;
    localparam int                PHASES    = 6;
    localparam int                PHASE_LEN = 125;
    localparam int                DRAIN_CYC = 64;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [SCALE_W-1:0]   i_cfg_data = '0;
    logic                 push = 1'b0;
    logic                 full;
    logic [FUNC_W-1:0]    i_func = '0;
    logic [AXIS_W-1:0]    i_axis = '0;
    logic [VAL_W-1:0]     i_value = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [VAL_W-1:0]     o_result;
    logic                 o_bad_axis;
    logic                 o_saturated;
    int                   n_errors;
    int                   n_pending;
    int                   pop_left = 0;

    axis_motion_unit_scaler dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_func     (i_func),
        .i_axis     (i_axis),
        .i_value    (i_value),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result),
        .o_bad_axis (o_bad_axis),
        .o_saturated(o_saturated)
    );

    amus_scaler_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .i_full     (full),
        .i_func     (i_func),
        .i_axis     (i_axis),
        .i_value    (i_value),
        .i_empty    (empty),
        .i_pop      (pop),
        .i_result   (o_result),
        .i_bad_axis (o_bad_axis),
        .i_saturated(o_saturated),
        .o_errors   (n_errors),
        .o_pending  (n_pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // random magnitude size so small and huge values both show up
    function automatic logic [VAL_W-1:0] rand_value();
        logic [63:0]      w;
        logic [VAL_W-1:0] v;
        int               k;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2: v = w[VAL_W-1:0];
            3: begin
                case ($urandom_range(0, 7))
                    0: v = VAL_MAX;
                    1: v = VAL_MIN;
                    2: v = '0;
                    3: v = VAL_W'(1);
                    4: v = '1;
                    5: v = ONE_Q;
                    6: v = -ONE_Q;
                    default: v = ONE_Q >> 1;
                endcase
            end
            default: begin
                k = $urandom_range(1, VAL_W - 1);
                v = w[VAL_W-1:0] & ((VAL_W'(1) << k) - 1);
                if (w[63]) v = -v;
            end
        endcase
        return v;
    endfunction

    function automatic logic [SCALE_W-1:0] rand_scale();
        logic [SCALE_W-1:0] w;
        w = $urandom;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return SCALE_W'(1);
            2: return '1;
            3: return SCALE_DEF;
            4, 5: return w;
            default: return w & ((SCALE_W'(1) << $urandom_range(12, 28)) - 1);
        endcase
    endfunction

    task automatic send(input logic [FUNC_W-1:0] fn, input logic [AXIS_W-1:0] ax,
                        input logic [VAL_W-1:0] v);
        push    <= 1'b1;
        i_func  <= fn;
        i_axis  <= ax;
        i_value <= v;
        do @(posedge i_clk); while (full);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        push <= 1'b0;
        do @(posedge i_clk); while (n_pending != 0);
    endtask

    task automatic load_scales(input logic [SCALE_W-1:0] tbl [MAX_AXES]);
        for (int i = 0; i < MAX_AXES; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(i);
            i_cfg_data <= tbl[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // result side: bursts of pop high, random stalls, some long clean runs
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (pop_left != 0) begin
            pop_left <= pop_left - 1;
        end else if (pop) begin
            pop      <= 1'b0;
            pop_left <= pick_gap();
        end else begin
            pop      <= 1'b1;
            pop_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(0, 30);
        end
    end

    initial begin : stim
        logic [SCALE_W-1:0] tbl [MAX_AXES];
        logic [FUNC_W-1:0]  fn;
        logic [AXIS_W-1:0]  ax;
        int                 gap;
        bit                 quiet;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset scales (1000.0): every code once, plus invalid axes
        for (int f = 0; f < (1 << FUNC_W); f++)
            send(FUNC_W'(f), AXIS_W'(f), ONE_Q + (ONE_Q >> 1));
        send(FUNC_SCALE_QRY, AXIS_W'(8), '0);
        send(FUNC_POS_TO_PUL, AXIS_W'(15), '1);
        drain();

        // zero, minimum, maximum and unit scales
        tbl[0] = '0;
        tbl[1] = SCALE_W'(1);
        tbl[2] = '1;
        tbl[3] = SCALE_DEF;
        tbl[4] = SCALE_W'(1) << SCALE_FRAC;
        tbl[5] = SCALE_W'(1) << (SCALE_FRAC - 1);
        tbl[6] = rand_scale();
        tbl[7] = $urandom;
        load_scales(tbl);
        send(FUNC_POS_TO_PUL, AXIS_W'(2), VAL_MAX);
        send(FUNC_POS_TO_PUL, AXIS_W'(2), VAL_MIN);
        send(FUNC_PUL_TO_ACC, AXIS_W'(1), VAL_MAX);
        send(FUNC_PUL_TO_ACC, AXIS_W'(1), VAL_MIN);
        send(FUNC_PUL_TO_POS, AXIS_W'(4), -(ONE_Q + (ONE_Q >> 1)));
        send(FUNC_PUL_TO_POS, AXIS_W'(4), (ONE_Q >> 1) + (ONE_Q >> 2));
        send(FUNC_SCALE_QRY, AXIS_W'(0), '0);
        send(FUNC_SCALE_QRY, AXIS_W'(2), VAL_MAX);
        send(FUNC_SCALE_QRY, AXIS_W'(8), VAL_MIN);
        send(FUNC_PUL_TO_VEL, AXIS_W'(0), VAL_MIN);
        send(FUNC_VEL_TO_PUL, AXIS_W'(2), VAL_MAX);
        send(FUNC_ACC_TO_PUL, AXIS_W'(2), VAL_MIN);
        send(FUNC_NONE, AXIS_W'(15), VAL_MIN);
        send(FUNC_POS_TO_PUL, AXIS_W'(5), VAL_W'(1));
        drain();

        for (int p = 0; p < PHASES; p++) begin
            for (int i = 0; i < MAX_AXES; i++) begin
                case (p)
                    0: tbl[i] = $urandom;
                    1: tbl[i] = '0;
                    2: tbl[i] = '1;
                    3: tbl[i] = SCALE_W'(1);
                    default: tbl[i] = rand_scale();
                endcase
            end
            load_scales(tbl);
            quiet = 1'b0;
            for (int n = 0; n < PHASE_LEN; n++) begin
                if (n % 25 == 0) quiet = ($urandom_range(0, 3) == 0);
                fn = ($urandom_range(0, 15) == 15) ? FUNC_NONE
                                                   : FUNC_W'($urandom_range(0, 6));
                ax = ($urandom_range(0, 9) == 9) ? AXIS_W'($urandom_range(8, 15))
                                                 : AXIS_W'($urandom_range(0, 7));
                send(fn, ax, rand_value());
                if ($urandom_range(0, 79) == 0) begin
                    drain();
                end else begin
                    gap = quiet ? 0 : pick_gap();
                    if (gap > 0) begin
                        push <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                end
            end
            drain();
        end

        repeat (DRAIN_CYC) @(posedge i_clk);
        if (n_errors == 0 && n_pending == 0)
            $display("axis_motion_unit_scaler test passed");
        else
            $display("axis_motion_unit_scaler test failed");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("axis_motion_unit_scaler test failed");
        $finish;
    end

endmodule
